// ===== hw/rtl/segment_intersection_unit_assert.svh =====
// Assertion macros for the segment intersection unit.
// Expects signals clk and rst in the scope of use; compiled out with NO_ASSERTIONS.
`ifndef SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// ante implies cons in the same cycle
`define SI_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection: implication check failed");
// cond must never hold
`define SI_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("segment intersection: forbidden condition seen");
`else
`define SI_ASSERT_IMPL(name, ante, cons)
`define SI_ASSERT_NEVER(name, cond)
`endif
`endif

// ===== hw/rtl/segint_pkg.sv =====
// Shared types and constants for the segment intersection unit.
// No dependencies.
`default_nettype none

package segint_pkg;

  // default coordinate width (signed Q12.4)
  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  // control bits that travel alongside each request in the pipeline
  typedef struct packed {
    logic vld;
    logic hit;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/segment_intersection_unit.sv =====
// Channel   Handshake              Payload
// request   start in, busy out     first_start_x .. second_end_y
// result    done strobe out        hit, point_x, point_y
//
// One request per cycle; busy is held low. The pipeline is five front stages,
// two scaling stages, one divider stage per quotient bit and two point stages.
// The bit-per-stage divider sets the depth.
// Synchronous reset clears every valid bit; payload registers are not reset.
// Nothing stalls: results leave on done and must be taken in that cycle.
//
// Top level of the segment intersection unit. Depends on segint_pkg,
// segint_front, segint_scale, segint_divider, segint_point and the assert header.
`default_nettype none

module segment_intersection_unit #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  output logic                          done,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y
);
  import segint_pkg::*;

  localparam int unsigned W             = COORD_WIDTH;
  localparam int unsigned FRONT_STAGES  = 5;
  localparam int unsigned SCALE_STAGES  = 2;
  localparam int unsigned POINT_STAGES  = 2;
  localparam int unsigned LATENCY       = FRONT_STAGES + SCALE_STAGES + W + POINT_STAGES;

  // fully pipelined: a request is taken every cycle
  assign busy = 1'b0;

  // front end to scaling
  ctl_t                f_ctl;
  logic [2*W:0]        f_tn, f_div;
  logic [W-1:0]        f_s1xm, f_s1ym;
  logic                f_s1xn, f_s1yn;
  logic signed [W-1:0] f_bx, f_by;

  segint_front #(.COORD_WIDTH(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start & ~busy),
    .ax      (first_start_x),
    .ay      (first_start_y),
    .bx      (first_end_x),
    .by      (first_end_y),
    .cx      (second_start_x),
    .cy      (second_start_y),
    .ex      (second_end_x),
    .ey      (second_end_y),
    .ctl     (f_ctl),
    .tn_mag  (f_tn),
    .div_mag (f_div),
    .s1x_mag (f_s1xm),
    .s1y_mag (f_s1ym),
    .s1x_neg (f_s1xn),
    .s1y_neg (f_s1yn),
    .base_x  (f_bx),
    .base_y  (f_by)
  );

  // scaling to divider
  ctl_t                s_ctl;
  logic [3*W:0]        s_nx, s_ny;
  logic [2*W:0]        s_div;
  logic                s_negx, s_negy;
  logic signed [W-1:0] s_bx, s_by;

  segint_scale #(.COORD_WIDTH(W)) u_scale (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (f_ctl),
    .tn_mag     (f_tn),
    .div_in     (f_div),
    .s1x_mag    (f_s1xm),
    .s1y_mag    (f_s1ym),
    .neg_x_in   (f_s1xn),
    .neg_y_in   (f_s1yn),
    .base_x_in  (f_bx),
    .base_y_in  (f_by),
    .ctl_out    (s_ctl),
    .num_x      (s_nx),
    .num_y      (s_ny),
    .div_out    (s_div),
    .neg_x_out  (s_negx),
    .neg_y_out  (s_negy),
    .base_x_out (s_bx),
    .base_y_out (s_by)
  );

  // divider to point assembly
  ctl_t                d_ctl;
  logic [W-1:0]        d_qx, d_qy;
  logic                d_rnx, d_rny, d_negx, d_negy;
  logic signed [W-1:0] d_bx, d_by;

  segint_divider #(.COORD_WIDTH(W)) u_divider (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (s_ctl),
    .num_x      (s_nx),
    .num_y      (s_ny),
    .den        (s_div),
    .neg_x_in   (s_negx),
    .neg_y_in   (s_negy),
    .base_x_in  (s_bx),
    .base_y_in  (s_by),
    .ctl_out    (d_ctl),
    .quo_x      (d_qx),
    .quo_y      (d_qy),
    .rem_nz_x   (d_rnx),
    .rem_nz_y   (d_rny),
    .neg_x_out  (d_negx),
    .neg_y_out  (d_negy),
    .base_x_out (d_bx),
    .base_y_out (d_by)
  );

  segint_point #(.COORD_WIDTH(W)) u_point (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (d_ctl),
    .quo_x    (d_qx),
    .quo_y    (d_qy),
    .rem_nz_x (d_rnx),
    .rem_nz_y (d_rny),
    .neg_x    (d_negx),
    .neg_y    (d_negy),
    .base_x   (d_bx),
    .base_y   (d_by),
    .done     (done),
    .hit      (hit),
    .point_x  (point_x),
    .point_y  (point_y)
  );

  // checks
`include "segment_intersection_unit_assert.svh"

  `SI_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, LATENCY))
  `SI_ASSERT_NEVER(a_hit_without_done, hit && !done)
  `SI_ASSERT_IMPL(a_miss_point_zero, done && !hit, point_x == '0 && point_y == '0)
  `SI_ASSERT_IMPL(a_div_hit_valid, d_ctl.hit, d_ctl.vld)

endmodule

`default_nettype wire

// ===== hw/rtl/segint_front.sv =====
// Front end: edge vectors, cross products, sign normalisation and the hit test.
// Five register stages. Depends on segint_pkg.
`default_nettype none

module segint_front #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_vld,
  input  logic signed [COORD_WIDTH-1:0]   ax,
  input  logic signed [COORD_WIDTH-1:0]   ay,
  input  logic signed [COORD_WIDTH-1:0]   bx,
  input  logic signed [COORD_WIDTH-1:0]   by,
  input  logic signed [COORD_WIDTH-1:0]   cx,
  input  logic signed [COORD_WIDTH-1:0]   cy,
  input  logic signed [COORD_WIDTH-1:0]   ex,
  input  logic signed [COORD_WIDTH-1:0]   ey,
  output segint_pkg::ctl_t                ctl,
  output logic        [2*COORD_WIDTH:0]   tn_mag,
  output logic        [2*COORD_WIDTH:0]   div_mag,
  output logic        [COORD_WIDTH-1:0]   s1x_mag,
  output logic        [COORD_WIDTH-1:0]   s1y_mag,
  output logic                            s1x_neg,
  output logic                            s1y_neg,
  output logic signed [COORD_WIDTH-1:0]   base_x,
  output logic signed [COORD_WIDTH-1:0]   base_y
);
  import segint_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;        // edge vector width
  localparam int unsigned XW = 2 * W + 2;    // product / cross width
  localparam int unsigned MW = 2 * W + 1;    // magnitude after normalising

  // stage 1: edge vectors
  logic                 v1;
  logic signed [DW-1:0] s1x1, s1y1, s2x1, s2y1, dx1, dy1;
  logic signed [W-1:0]  ax1, ay1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1x1 <= {bx[W-1], bx} - {ax[W-1], ax};
    s1y1 <= {by[W-1], by} - {ay[W-1], ay};
    s2x1 <= {ex[W-1], ex} - {cx[W-1], cx};
    s2y1 <= {ey[W-1], ey} - {cy[W-1], cy};
    dx1  <= {ax[W-1], ax} - {cx[W-1], cx};
    dy1  <= {ay[W-1], ay} - {cy[W-1], cy};
    ax1  <= ax;
    ay1  <= ay;
  end

  // stage 2: six products, magnitudes of the first edge
  logic                 v2;
  logic signed [XW-1:0] pa2, pb2, pc2, pd2, pe2, pf2;
  logic        [W-1:0]  s1xm2, s1ym2;
  logic                 s1xn2, s1yn2;
  logic signed [W-1:0]  ax2, ay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pa2   <= s1x1 * s2y1;
    pb2   <= s2x1 * s1y1;
    pc2   <= s1x1 * dy1;
    pd2   <= s1y1 * dx1;
    pe2   <= s2x1 * dy1;
    pf2   <= s2y1 * dx1;
    s1xm2 <= W'(s1x1[DW-1] ? -s1x1 : s1x1);
    s1ym2 <= W'(s1y1[DW-1] ? -s1y1 : s1y1);
    s1xn2 <= s1x1[DW-1];
    s1yn2 <= s1y1[DW-1];
    ax2   <= ax1;
    ay2   <= ay1;
  end

  // stage 3: divisor and the two numerators
  logic                 v3;
  logic signed [XW-1:0] dv3, sn3, tn3;
  logic        [W-1:0]  s1xm3, s1ym3;
  logic                 s1xn3, s1yn3;
  logic signed [W-1:0]  ax3, ay3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dv3   <= pa2 - pb2;
    sn3   <= pc2 - pd2;
    tn3   <= pe2 - pf2;
    s1xm3 <= s1xm2;
    s1ym3 <= s1ym2;
    s1xn3 <= s1xn2;
    s1yn3 <= s1yn2;
    ax3   <= ax2;
    ay3   <= ay2;
  end

  // stage 4: flip all three so the divisor is non-negative
  logic                 v4;
  logic signed [XW-1:0] dv4, sn4, tn4;
  logic        [W-1:0]  s1xm4, s1ym4;
  logic                 s1xn4, s1yn4;
  logic signed [W-1:0]  ax4, ay4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dv4   <= dv3[XW-1] ? -dv3 : dv3;
    sn4   <= dv3[XW-1] ? -sn3 : sn3;
    tn4   <= dv3[XW-1] ? -tn3 : tn3;
    s1xm4 <= s1xm3;
    s1ym4 <= s1ym3;
    s1xn4 <= s1xn3;
    s1yn4 <= s1yn3;
    ax4   <= ax3;
    ay4   <= ay3;
  end

  // stage 5: both parameters in [0,1] and divisor nonzero
  logic hit_test;

  assign hit_test = (dv4 != '0) && !sn4[XW-1] && (sn4 <= dv4)
                    && !tn4[XW-1] && (tn4 <= dv4);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.vld <= v4;
      ctl.hit <= v4 & hit_test;
    end
  end

  always_ff @(posedge clk) begin
    tn_mag  <= tn4[MW-1:0];
    div_mag <= dv4[MW-1:0];
    s1x_mag <= s1xm4;
    s1y_mag <= s1ym4;
    s1x_neg <= s1xn4;
    s1y_neg <= s1yn4;
    base_x  <= ax4;
    base_y  <= ay4;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/segint_scale.sv =====
// Scaling: |t_num * s1| for both axes as split partial products, then summed.
// Two register stages. Depends on segint_pkg.
`default_nettype none

module segint_scale #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  segint_pkg::ctl_t                ctl_in,
  input  logic        [2*COORD_WIDTH:0]   tn_mag,
  input  logic        [2*COORD_WIDTH:0]   div_in,
  input  logic        [COORD_WIDTH-1:0]   s1x_mag,
  input  logic        [COORD_WIDTH-1:0]   s1y_mag,
  input  logic                            neg_x_in,
  input  logic                            neg_y_in,
  input  logic signed [COORD_WIDTH-1:0]   base_x_in,
  input  logic signed [COORD_WIDTH-1:0]   base_y_in,
  output segint_pkg::ctl_t                ctl_out,
  output logic        [3*COORD_WIDTH:0]   num_x,
  output logic        [3*COORD_WIDTH:0]   num_y,
  output logic        [2*COORD_WIDTH:0]   div_out,
  output logic                            neg_x_out,
  output logic                            neg_y_out,
  output logic signed [COORD_WIDTH-1:0]   base_x_out,
  output logic signed [COORD_WIDTH-1:0]   base_y_out
);
  import segint_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned NW = 3 * W + 1;

  // stage 1: low half of t_num is W+1 bits, high half W bits
  ctl_t                ctl1;
  logic [2*W:0]        plx1, ply1;
  logic [2*W-1:0]      phx1, phy1;
  logic [MW-1:0]       d1;
  logic                nx1, ny1;
  logic signed [W-1:0] bx1, by1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    plx1 <= tn_mag[W:0] * s1x_mag;
    ply1 <= tn_mag[W:0] * s1y_mag;
    phx1 <= tn_mag[MW-1:W+1] * s1x_mag;
    phy1 <= tn_mag[MW-1:W+1] * s1y_mag;
    d1   <= div_in;
    nx1  <= neg_x_in;
    ny1  <= neg_y_in;
    bx1  <= base_x_in;
    by1  <= base_y_in;
  end

  // stage 2: recombine the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    num_x      <= (NW'(phx1) << (W + 1)) + NW'(plx1);
    num_y      <= (NW'(phy1) << (W + 1)) + NW'(ply1);
    div_out    <= d1;
    neg_x_out  <= nx1;
    neg_y_out  <= ny1;
    base_x_out <= bx1;
    base_y_out <= by1;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/segint_divider.sv =====
// Restoring divider, one quotient bit per register stage, two lanes (x and y)
// sharing one divisor. COORD_WIDTH stages. Depends on segint_pkg.
`default_nettype none

module segint_divider #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  segint_pkg::ctl_t                ctl_in,
  input  logic        [3*COORD_WIDTH:0]   num_x,
  input  logic        [3*COORD_WIDTH:0]   num_y,
  input  logic        [2*COORD_WIDTH:0]   den,
  input  logic                            neg_x_in,
  input  logic                            neg_y_in,
  input  logic signed [COORD_WIDTH-1:0]   base_x_in,
  input  logic signed [COORD_WIDTH-1:0]   base_y_in,
  output segint_pkg::ctl_t                ctl_out,
  output logic        [COORD_WIDTH-1:0]   quo_x,
  output logic        [COORD_WIDTH-1:0]   quo_y,
  output logic                            rem_nz_x,
  output logic                            rem_nz_y,
  output logic                            neg_x_out,
  output logic                            neg_y_out,
  output logic signed [COORD_WIDTH-1:0]   base_x_out,
  output logic signed [COORD_WIDTH-1:0]   base_y_out
);
  import segint_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned NW = 3 * W + 1;

  // everything one divider stage carries
  typedef struct packed {
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
    logic [MW-1:0] d;
    logic [W-1:0]  qx;
    logic [W-1:0]  qy;
    logic          negx;
    logic          negy;
    logic [W-1:0]  bx;
    logic [W-1:0]  by;
  } lane_t;

  lane_t lane_in;
  lane_t lane  [W];
  ctl_t  ctl_q [W];

  always_comb begin
    lane_in.rx   = num_x;
    lane_in.ry   = num_y;
    lane_in.d    = den;
    lane_in.qx   = '0;
    lane_in.qy   = '0;
    lane_in.negx = neg_x_in;
    lane_in.negy = neg_y_in;
    lane_in.bx   = base_x_in;
    lane_in.by   = base_y_in;
  end

  // quotient bits MSB first: stage k tries the divisor shifted by W-1-k
  for (genvar k = 0; k < W; k++) begin : g_step
    localparam int unsigned SH = W - 1 - k;
    lane_t         src;
    lane_t         lane_next;
    ctl_t          src_ctl;
    logic [NW-1:0] dsh;
    logic [NW:0]   tx, ty;

    if (k == 0) begin : g_first
      assign src     = lane_in;
      assign src_ctl = ctl_in;
    end else begin : g_next
      assign src     = lane[k-1];
      assign src_ctl = ctl_q[k-1];
    end

    assign dsh = NW'(src.d) << SH;
    assign tx  = {1'b0, src.rx} - {1'b0, dsh};
    assign ty  = {1'b0, src.ry} - {1'b0, dsh};

    // trial subtract; a borrow means this bit is 0 and the remainder stays
    always_comb begin
      lane_next    = src;
      lane_next.rx = tx[NW] ? src.rx : tx[NW-1:0];
      lane_next.ry = ty[NW] ? src.ry : ty[NW-1:0];
      lane_next.qx = {src.qx[W-2:0], ~tx[NW]};
      lane_next.qy = {src.qy[W-2:0], ~ty[NW]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      lane[k] <= lane_next;
    end
  end

  // last stage drives the outputs
  assign ctl_out    = ctl_q[W-1];
  assign quo_x      = lane[W-1].qx;
  assign quo_y      = lane[W-1].qy;
  assign rem_nz_x   = |lane[W-1].rx;
  assign rem_nz_y   = |lane[W-1].ry;
  assign neg_x_out  = lane[W-1].negx;
  assign neg_y_out  = lane[W-1].negy;
  assign base_x_out = lane[W-1].bx;
  assign base_y_out = lane[W-1].by;

endmodule

`default_nettype wire

// ===== hw/rtl/segint_point.sv =====
// Point assembly: signs the quotient, adds the start point, truncates to zero.
// Two register stages, the second is the result register. Depends on segint_pkg.
`default_nettype none

module segint_point #(
  parameter int unsigned COORD_WIDTH = segint_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  segint_pkg::ctl_t                ctl_in,
  input  logic        [COORD_WIDTH-1:0]   quo_x,
  input  logic        [COORD_WIDTH-1:0]   quo_y,
  input  logic                            rem_nz_x,
  input  logic                            rem_nz_y,
  input  logic                            neg_x,
  input  logic                            neg_y,
  input  logic signed [COORD_WIDTH-1:0]   base_x,
  input  logic signed [COORD_WIDTH-1:0]   base_y,
  output logic                            done,
  output logic                            hit,
  output logic signed [COORD_WIDTH-1:0]   point_x,
  output logic signed [COORD_WIDTH-1:0]   point_y
);
  import segint_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  // stage 1: floor quotient; for a negative product it is -q - (rem != 0)
  ctl_t                ctl1;
  logic [W:0]          fqx1, fqy1;
  logic                rnx1, rny1;
  logic signed [W-1:0] bx1, by1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    fqx1 <= neg_x ? (~{1'b0, quo_x} + (W+1)'(!rem_nz_x)) : {1'b0, quo_x};
    fqy1 <= neg_y ? (~{1'b0, quo_y} + (W+1)'(!rem_nz_y)) : {1'b0, quo_y};
    rnx1 <= rem_nz_x;
    rny1 <= rem_nz_y;
    bx1  <= base_x;
    by1  <= base_y;
  end

  // stage 2: floor sum, then step up by one when negative with a remainder
  logic [W+1:0] sumx, sumy, ptx, pty;

  always_comb begin
    sumx = {{2{bx1[W-1]}}, bx1} + {fqx1[W], fqx1};
    sumy = {{2{by1[W-1]}}, by1} + {fqy1[W], fqy1};
    ptx  = sumx + (W+2)'(sumx[W+1] & rnx1);
    pty  = sumy + (W+2)'(sumy[W+1] & rny1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= ctl1.vld;
      hit  <= ctl1.vld & ctl1.hit;
    end
  end

  always_ff @(posedge clk) begin
    point_x <= (ctl1.vld & ctl1.hit) ? ptx[W-1:0] : '0;
    point_y <= (ctl1.vld & ctl1.hit) ? pty[W-1:0] : '0;
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for segment_intersection_unit: drives segment pairs, predicts
// hit flag and crossing point exactly, and checks every result strobed out on done.
// Depends on segint_pkg and segment_intersection_unit.
`timescale 1ns / 1ps

module testbench;

  localparam int CW = segint_pkg::COORD_WIDTH_DEFAULT;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_TAIL = 120;     // last random requests sent back to back
  localparam int DRAIN_CYCLES = 40;    // beyond the pipeline depth
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [127:0] wide_t;

  // one request: two segments, start and end point each
  typedef struct {
    logic signed [CW-1:0] p0x, p0y, p1x, p1y;  // first segment
    logic signed [CW-1:0] q0x, q0y, q1x, q1y;  // second segment
  } seg_pair_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] px, py;
  } crossing_t;

  // Scoreboard: predicts each request's crossing and checks results in order
  class crossing_scoreboard;
    crossing_t   pending_crossings[$];
    int unsigned failures;
    int unsigned hits;
    int unsigned misses;

    function new();
      failures = 0;
      hits = 0;
      misses = 0;
    endfunction

    // num/den in [0,1], den nonzero
    function bit in_unit_range(wide_t num, wide_t den);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      return (num >= 0) && (num <= den);
    endfunction

    function crossing_t crossing_of(seg_pair_t p);
      wide_t     ax, ay, cx, cy;
      wide_t     s1x, s1y, s2x, s2y, dx, dy;
      wide_t     dv, sn, tn, qx, qy;
      crossing_t r;
      ax = p.p0x;
      ay = p.p0y;
      cx = p.q0x;
      cy = p.q0y;
      s1x = wide_t'(p.p1x) - ax;
      s1y = wide_t'(p.p1y) - ay;
      s2x = wide_t'(p.q1x) - cx;
      s2y = wide_t'(p.q1y) - cy;
      dx = ax - cx;
      dy = ay - cy;
      dv = s1x * s2y - s2x * s1y;
      sn = s1x * dy - s1y * dx;
      tn = s2x * dy - s2y * dx;
      r.hit = 1'b0;
      r.px = '0;
      r.py = '0;
      // zero divisor means parallel or collinear: never a hit
      if (dv != 0 && in_unit_range(sn, dv) && in_unit_range(tn, dv)) begin
        // exact rational point, SV division truncates toward zero
        qx = (ax * dv + tn * s1x) / dv;
        qy = (ay * dv + tn * s1y) / dv;
        r.hit = 1'b1;
        r.px = qx[CW-1:0];
        r.py = qy[CW-1:0];
      end
      return r;
    endfunction

    function void note_request(seg_pair_t p);
      crossing_t c;
      c = crossing_of(p);
      if (c.hit) hits++;
      else misses++;
      pending_crossings.push_back(c);
    endfunction

    function void check_result(logic got_hit, logic signed [CW-1:0] got_x,
                               logic signed [CW-1:0] got_y);
      crossing_t want;
      if (pending_crossings.size() == 0) begin
        $display("%0t: unexpected result: hit %0d x %0d y %0d", $time, got_hit, got_x,
                 got_y);
        failures++;
        return;
      end
      want = pending_crossings.pop_front();
      if (got_hit !== want.hit) begin
        $display("%0t: mismatch on hit: expected %0d, actual %0d", $time, want.hit,
                 got_hit);
        failures++;
      end
      if (got_x !== want.px) begin
        $display("%0t: mismatch on point_x: expected %0d, actual %0d", $time, want.px,
                 got_x);
        failures++;
      end
      if (got_y !== want.py) begin
        $display("%0t: mismatch on point_y: expected %0d, actual %0d", $time, want.py,
                 got_y);
        failures++;
      end
    endfunction

    function int pending();
      return pending_crossings.size();
    endfunction

    function void close_out();
      if (pending_crossings.size() != 0) begin
        $display("%0t: %0d results never arrived", $time, pending_crossings.size());
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] first_start_x, first_start_y, first_end_x, first_end_y;
  logic signed [CW-1:0] second_start_x, second_start_y, second_end_x, second_end_y;
  logic                 done;
  logic                 hit;
  logic signed [CW-1:0] point_x, point_y;

  crossing_scoreboard crossings;
  int unsigned        cycle_count;

  segment_intersection_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .first_start_x (first_start_x),
    .first_start_y (first_start_y),
    .first_end_x   (first_end_x),
    .first_end_y   (first_end_y),
    .second_start_x(second_start_x),
    .second_start_y(second_start_y),
    .second_end_x  (second_end_x),
    .second_end_y  (second_end_y),
    .done          (done),
    .hit           (hit),
    .point_x       (point_x),
    .point_y       (point_y)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // monitor: note accepted requests, check strobed results
  always @(posedge clk) begin
    seg_pair_t seen;
    if (!rst && start && !busy) begin
      seen.p0x = first_start_x;
      seen.p0y = first_start_y;
      seen.p1x = first_end_x;
      seen.p1y = first_end_y;
      seen.q0x = second_start_x;
      seen.q0y = second_start_y;
      seen.q1x = second_end_x;
      seen.q1y = second_end_y;
      crossings.note_request(seen);
    end
    if (!rst && done) crossings.check_result(hit, point_x, point_y);
  end

  function automatic seg_pair_t pair_of(int ax, int ay, int bx, int by,
                                        int cx, int cy, int ex, int ey);
    seg_pair_t p;
    p.p0x = CW'(ax);
    p.p0y = CW'(ay);
    p.p1x = CW'(bx);
    p.p1y = CW'(by);
    p.q0x = CW'(cx);
    p.q0y = CW'(cy);
    p.q1x = CW'(ex);
    p.q1y = CW'(ey);
    return p;
  endfunction

  // a corner value of the coordinate range, or now and then anything
  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($signed(CW'($urandom)));
    endcase
  endfunction

  function automatic int any_coord();
    return int'($signed(CW'($urandom)));
  endfunction

  function automatic int span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // mix of shapes: four in ten pairs cross, the rest are random, miss, run parallel or hit the extremes
  function automatic seg_pair_t random_pair();
    int px, py, ux, uy, vx, vy, k0, k1, k2, k3, sx, sy;
    px = span(8000);
    py = span(8000);
    ux = span(64);
    uy = span(64);
    vx = span(64);
    vy = span(64);
    k0 = $urandom_range(0, 100);
    k1 = $urandom_range(0, 100);
    k2 = $urandom_range(0, 100);
    k3 = $urandom_range(0, 100);
    sx = span(500);
    sy = span(500);
    case ($urandom_range(0, 9))
      // both segments through a common point; k of zero gives an endpoint touch
      0, 1, 2, 3:
        return pair_of(px - k0 * ux, py - k0 * uy, px + k1 * ux, py + k1 * uy,
                       px - k2 * vx, py - k2 * vy, px + k3 * vx, py + k3 * vy);
      4, 5:
        return pair_of(any_coord(), any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord(), any_coord(), any_coord());
      // tiny grid: parallel, collinear and touching cases are common
      6:
        return pair_of(span(4), span(4), span(4), span(4),
                       span(4), span(4), span(4), span(4));
      // parallel: shifted copy with scaled direction, sometimes collinear
      7: begin
        if ($urandom_range(0, 1) == 1) begin
          sx = ux * (k2 % 7 - 3);
          sy = uy * (k2 % 7 - 3);
        end
        return pair_of(px, py, px + k0 * ux, py + k0 * uy,
                       px + sx, py + sy, px + sx + (k3 % 5 - 2) * ux * 10,
                       py + sy + (k3 % 5 - 2) * uy * 10);
      end
      8:
        return pair_of(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                       edge_coord(), edge_coord(), edge_coord(), edge_coord());
      // near miss: second segment moved off the crossing point
      default:
        return pair_of(px - k0 * ux, py - k0 * uy, px + k1 * ux, py + k1 * uy,
                       px - k2 * vx + sx, py - k2 * vy + sy, px + k3 * vx + sx,
                       py + k3 * vy + sy);
    endcase
  endfunction

  // present one request from the falling edge and hold it until taken
  task automatic send_pair(seg_pair_t p);
    @(negedge clk);
    first_start_x = p.p0x;
    first_start_y = p.p0y;
    first_end_x = p.p1x;
    first_end_y = p.p1y;
    second_start_x = p.q0x;
    second_start_y = p.q0y;
    second_end_x = p.q1x;
    second_end_y = p.q1y;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // start held low over the given number of rising edges
  task automatic idle_for(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every outstanding result is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (crossings.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int drain_wait;
    crossings = new();
    cycle_count = 0;
    rst = 1'b1;
    start = 1'b0;
    first_start_x = '0;
    first_start_y = '0;
    first_end_x = '0;
    first_end_y = '0;
    second_start_x = '0;
    second_start_y = '0;
    second_end_x = '0;
    second_end_y = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed requests; 16 is 1.0 in Q12.4
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));                  // all degenerate
    send_pair(pair_of(0, 0, 16, 16, 0, 16, 16, 0));              // plain cross
    send_pair(pair_of(0, 0, 5, 5, 0, 5, 5, 0));                  // truncation, positive
    send_pair(pair_of(0, 0, -5, -5, 0, -5, -5, 0));              // truncation, negative
    send_pair(pair_of(8, 0, 8, 16, 0, 0, 16, 0));                // t exactly 0
    send_pair(pair_of(8, 16, 8, 0, 0, 0, 16, 0));                // t exactly 1
    send_pair(pair_of(0, 0, 16, 0, 8, 0, 8, 16));                // s exactly 0
    send_pair(pair_of(0, 0, 16, 0, 8, 16, 8, 0));                // s exactly 1
    send_pair(pair_of(0, 0, 16, 16, 16, 16, 32, 0));             // shared endpoint
    send_pair(pair_of(0, 0, 16, 16, 0, 8, 16, 24));              // parallel
    send_pair(pair_of(0, 0, 32, 0, 16, 0, 48, 0));               // collinear overlap
    send_pair(pair_of(0, 0, 16, 0, 32, -8, 32, 8));              // t beyond 1
    send_pair(pair_of(0, 0, 16, 0, -16, -8, -16, 8));            // t below 0
    send_pair(pair_of(0, 0, 16, 16, 0, 40, 40, 0));              // t beyond 1
    send_pair(pair_of(8, 0, 8, 0, 0, 0, 16, 0));                 // zero-length segment
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    send_pair(pair_of(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(pair_of(32767, 0, -32768, 0, 0, 32767, 0, -32768));
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_of(-1, -1, 1, 1, -1, 1, 1, -1));
    send_pair(pair_of(0, 0, 32, 32, 32, 32, 0, 0));              // same segment reversed
    drain();

    // random requests, with sender gaps except in the tail
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      else if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 19));
      send_pair(random_pair());
    end

    drain();
    drain_wait = DRAIN_CYCLES;
    repeat (drain_wait) @(posedge clk);
    crossings.close_out();

    $display("Run covered %0d segment pairs: %0d crossing, %0d apart or parallel.",
             crossings.hits + crossings.misses, crossings.hits, crossings.misses);
    if (crossings.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
